### sv/lldf_pkg.sv
// ---------------------------------------------------------------------------
// lldf_pkg: shared types and constants for the least-loaded dispatcher
// Payload structs, command/status structs between controller and datapath,
// function and result kind codes.
// ---------------------------------------------------------------------------
package lldf_pkg;

    localparam int NODE_COUNT  = 4;
    localparam int QUEUE_DEPTH = 16;

    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int CNT_BITS   = $clog2(NODE_COUNT + 1);
    localparam int PTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int FILL_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_BITS  = $clog2(NODE_COUNT * QUEUE_DEPTH);
    localparam int MEM_DEPTH  = NODE_COUNT * QUEUE_DEPTH;
    localparam int ID_BITS    = 16;
    localparam int TYPE_BITS  = 2;
    localparam int DONE_BITS  = 16;
    localparam int CFG_BITS   = 3;
    localparam int KIND_BITS  = 3;
    localparam int FUNC_BITS  = 2;
    localparam int ENTRY_BITS = ID_BITS + TYPE_BITS;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(4);

    localparam logic [FUNC_BITS-1:0] FUNC_ASSIGN = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_CRASH  = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_RUN    = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_STATUS = 2'd3;

    localparam logic [KIND_BITS-1:0] KIND_ASSIGNED = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_DROPPED  = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_EXECUTED = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_STATUS   = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_RUN_IDLE = 3'd4;
    localparam logic [KIND_BITS-1:0] KIND_REJECTED = 3'd5;

    typedef struct packed {
        logic [FUNC_BITS-1:0] func;
        logic [ID_BITS-1:0]   task_id;
        logic [TYPE_BITS-1:0] task_type;
        logic [NODE_BITS-1:0] node_index;
    } in_item_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [NODE_BITS-1:0] node;
        logic [ID_BITS-1:0]   task_id_res;
        logic [TYPE_BITS-1:0] task_type_res;
        logic                 alive;
        logic [DONE_BITS-1:0] done_count;
        logic                 last;
    } out_item_t;

    typedef struct packed {
        logic                 load_in;
        logic                 dispatch;
        logic                 src_pop;
        logic                 crash_stat;
        logic                 reject;
        logic                 pop;
        logic                 pop_crash;
        logic                 exec;
        logic                 stat;
        logic                 idle;
        logic                 last;
        logic [NODE_BITS-1:0] cur;
    } dp_cmd_t;

    typedef struct packed {
        logic                 emit_ok;
        logic                 reject;
        logic                 idx_fill_zero;
        logic                 cur_work;
        logic                 more_work;
        logic                 last_node;
    } dp_stat_t;

endpackage

### sv/lldf_dp.sv
// ---------------------------------------------------------------------------
// lldf_dp: dispatcher datapath
// Per-node queue pointers, alive flags and done counters, the shared task
// memory, least-loaded selection, input latch and result register.
// ---------------------------------------------------------------------------
module lldf_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lldf_pkg::in_item_t            s_data,
    output lldf_pkg::out_item_t           m_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          cfg_wr_en,
    input  logic [lldf_pkg::CFG_BITS-1:0] cfg_wr_data,
    input  lldf_pkg::dp_cmd_t             cmd,
    output lldf_pkg::dp_stat_t            stat
);

    logic [lldf_pkg::PTR_BITS-1:0]   head_reg  [lldf_pkg::NODE_COUNT];
    logic [lldf_pkg::PTR_BITS-1:0]   head_next [lldf_pkg::NODE_COUNT];
    logic [lldf_pkg::FILL_BITS-1:0]  fill_reg  [lldf_pkg::NODE_COUNT];
    logic [lldf_pkg::FILL_BITS-1:0]  fill_next [lldf_pkg::NODE_COUNT];
    logic [lldf_pkg::DONE_BITS-1:0]  done_reg  [lldf_pkg::NODE_COUNT];
    logic [lldf_pkg::DONE_BITS-1:0]  done_next [lldf_pkg::NODE_COUNT];
    logic [lldf_pkg::NODE_COUNT-1:0] alive_reg, alive_next;
    logic [lldf_pkg::CFG_BITS-1:0]   cfg_reg, cfg_next;
    lldf_pkg::in_item_t              in_reg;
    lldf_pkg::out_item_t             out_reg, out_next;
    logic                            out_valid_reg, out_valid_next;

    logic [lldf_pkg::ENTRY_BITS-1:0] task_store_reg [lldf_pkg::MEM_DEPTH];
    logic [lldf_pkg::ENTRY_BITS-1:0] rd_data_reg;

    logic [lldf_pkg::CNT_BITS-1:0]   n_use;
    logic [lldf_pkg::NODE_COUNT-1:0] work;
    logic                            found;
    logic [lldf_pkg::NODE_BITS-1:0]  sel;
    logic [lldf_pkg::NODE_BITS-1:0]  idx;
    logic [lldf_pkg::NODE_BITS-1:0]  pop_node;
    logic [lldf_pkg::PTR_BITS:0]     slot_sum;
    logic [lldf_pkg::PTR_BITS-1:0]   slot;
    logic [lldf_pkg::ADDR_BITS-1:0]  wr_addr, rd_addr;
    logic [lldf_pkg::ID_BITS-1:0]    src_id;
    logic [lldf_pkg::TYPE_BITS-1:0]  src_type;
    logic                            emit;
    logic                            more;

    assign idx      = in_reg.node_index;
    assign pop_node = cmd.pop_crash ? idx : cmd.cur;
    assign emit     = cmd.dispatch | cmd.crash_stat | cmd.reject |
                      cmd.exec | cmd.stat | cmd.idle;

    always_comb begin
        if (cfg_reg == '0) begin
            n_use = lldf_pkg::CNT_BITS'(1);
        end else if (int'(cfg_reg) > lldf_pkg::NODE_COUNT) begin
            n_use = lldf_pkg::CNT_BITS'(lldf_pkg::NODE_COUNT);
        end else begin
            n_use = lldf_pkg::CNT_BITS'(cfg_reg);
        end
    end

    // least-loaded alive node, lowest index on ties
    always_comb begin
        found = 1'b0;
        sel   = '0;
        more  = 1'b0;
        for (int i = 0; i < lldf_pkg::NODE_COUNT; i++) begin
            work[i] = (i < int'(n_use)) && alive_reg[i] && (fill_reg[i] != '0);
            if (i >= int'(cmd.cur) && work[i]) begin
                more = 1'b1;
            end
            if ((i < int'(n_use)) && alive_reg[i] &&
                (int'(fill_reg[i]) < lldf_pkg::QUEUE_DEPTH)) begin
                if (!found || (fill_reg[i] < fill_reg[sel])) begin
                    found = 1'b1;
                    sel   = lldf_pkg::NODE_BITS'(i);
                end
            end
        end
    end

    always_comb begin
        slot_sum = (lldf_pkg::PTR_BITS+1)'(head_reg[sel]) +
                   (lldf_pkg::PTR_BITS+1)'(fill_reg[sel]);
        if (int'(slot_sum) >= lldf_pkg::QUEUE_DEPTH) begin
            slot = lldf_pkg::PTR_BITS'(slot_sum -
                   (lldf_pkg::PTR_BITS+1)'(lldf_pkg::QUEUE_DEPTH));
        end else begin
            slot = lldf_pkg::PTR_BITS'(slot_sum);
        end
        wr_addr = lldf_pkg::ADDR_BITS'(sel) * lldf_pkg::ADDR_BITS'(lldf_pkg::QUEUE_DEPTH)
                + lldf_pkg::ADDR_BITS'(slot);
        rd_addr = lldf_pkg::ADDR_BITS'(pop_node)
                * lldf_pkg::ADDR_BITS'(lldf_pkg::QUEUE_DEPTH)
                + lldf_pkg::ADDR_BITS'(head_reg[pop_node]);
    end

    always_comb begin
        if (cmd.src_pop) begin
            src_id   = rd_data_reg[lldf_pkg::ENTRY_BITS-1:lldf_pkg::TYPE_BITS];
            src_type = rd_data_reg[lldf_pkg::TYPE_BITS-1:0];
        end else begin
            src_id   = in_reg.task_id;
            src_type = in_reg.task_type;
        end
    end

    always_comb begin
        head_next  = head_reg;
        fill_next  = fill_reg;
        done_next  = done_reg;
        alive_next = alive_reg;
        cfg_next   = cfg_wr_en ? cfg_wr_data : cfg_reg;

        if (cmd.dispatch && found) begin
            fill_next[sel] = fill_reg[sel] + lldf_pkg::FILL_BITS'(1);
        end
        if (cmd.pop) begin
            fill_next[pop_node] = fill_reg[pop_node] - lldf_pkg::FILL_BITS'(1);
            if (cmd.pop_crash && (fill_reg[pop_node] == lldf_pkg::FILL_BITS'(1))) begin
                head_next[pop_node] = '0;
            end else if (int'(head_reg[pop_node]) == lldf_pkg::QUEUE_DEPTH - 1) begin
                head_next[pop_node] = '0;
            end else begin
                head_next[pop_node] = head_reg[pop_node] + lldf_pkg::PTR_BITS'(1);
            end
        end
        if (cmd.crash_stat) begin
            alive_next[idx] = 1'b0;
            if (fill_reg[idx] == '0) begin
                head_next[idx] = '0;
            end
        end
        if (cmd.exec && (done_reg[cmd.cur] != '1)) begin
            done_next[cmd.cur] = done_reg[cmd.cur] + lldf_pkg::DONE_BITS'(1);
        end
    end

    always_comb begin
        out_next      = '0;
        out_next.last = cmd.last;
        if (cmd.dispatch) begin
            out_next.kind          = found ? lldf_pkg::KIND_ASSIGNED : lldf_pkg::KIND_DROPPED;
            out_next.node          = found ? sel : '0;
            out_next.task_id_res   = src_id;
            out_next.task_type_res = src_type;
        end else if (cmd.reject) begin
            out_next.kind = lldf_pkg::KIND_REJECTED;
            out_next.node = idx;
        end else if (cmd.crash_stat) begin
            out_next.kind       = lldf_pkg::KIND_STATUS;
            out_next.node       = idx;
            out_next.done_count = done_reg[idx];
        end else if (cmd.exec) begin
            out_next.kind          = lldf_pkg::KIND_EXECUTED;
            out_next.node          = cmd.cur;
            out_next.task_id_res   = rd_data_reg[lldf_pkg::ENTRY_BITS-1:lldf_pkg::TYPE_BITS];
            out_next.task_type_res = rd_data_reg[lldf_pkg::TYPE_BITS-1:0];
        end else if (cmd.stat) begin
            out_next.kind       = lldf_pkg::KIND_STATUS;
            out_next.node       = cmd.cur;
            out_next.alive      = alive_reg[cmd.cur];
            out_next.done_count = done_reg[cmd.cur];
        end else begin
            out_next.kind = lldf_pkg::KIND_RUN_IDLE;
        end
        if (emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < lldf_pkg::NODE_COUNT; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
                done_reg[i] <= '0;
            end
            alive_reg     <= '1;
            cfg_reg       <= lldf_pkg::CFG_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            done_reg      <= done_next;
            alive_reg     <= alive_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            in_reg <= s_data;
        end
        if (emit) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.dispatch && found) begin
            task_store_reg[wr_addr] <= {src_id, src_type};
        end
        if (cmd.pop) begin
            rd_data_reg <= task_store_reg[rd_addr];
        end
    end

    assign m_data  = out_reg;
    assign m_valid = out_valid_reg;

    assign stat.emit_ok       = !out_valid_reg || m_ready;
    assign stat.reject        = int'(idx) >= int'(n_use);
    assign stat.idx_fill_zero = fill_reg[idx] == '0;
    assign stat.cur_work      = work[cmd.cur];
    assign stat.more_work     = more;
    assign stat.last_node     = int'(cmd.cur) == int'(n_use) - 1;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> (!out_valid_reg || m_ready))
        else $error("result register overwritten");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |-> (fill_reg[pop_node] != '0))
        else $error("pop from empty queue");

    a_failover_dead: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.dispatch && cmd.src_pop) |-> !alive_reg[idx])
        else $error("failover from a live node");

endmodule

### sv/lldf_ctrl.sv
// ---------------------------------------------------------------------------
// lldf_ctrl: dispatcher controller
// Decodes each transaction and sequences assign, crash failover, queue
// drain and status report steps on the datapath.
// ---------------------------------------------------------------------------
module lldf_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [lldf_pkg::FUNC_BITS-1:0] s_func,
    output lldf_pkg::dp_cmd_t              cmd,
    input  lldf_pkg::dp_stat_t             stat
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ASG   = 3'd1;
    localparam logic [2:0] ST_CST   = 3'd2;
    localparam logic [2:0] ST_CRD   = 3'd3;
    localparam logic [2:0] ST_CDSP  = 3'd4;
    localparam logic [2:0] ST_RSCAN = 3'd5;
    localparam logic [2:0] ST_REMIT = 3'd6;
    localparam logic [2:0] ST_STAT  = 3'd7;

    logic [2:0]                     state_reg, state_next;
    logic [lldf_pkg::NODE_BITS-1:0] cur_reg, cur_next;

    always_comb begin
        state_next = state_reg;
        cur_next   = cur_reg;
        cmd        = '0;
        cmd.cur    = cur_reg;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cur_next    = '0;
                    case (s_func)
                        lldf_pkg::FUNC_ASSIGN: state_next = ST_ASG;
                        lldf_pkg::FUNC_CRASH:  state_next = ST_CST;
                        lldf_pkg::FUNC_RUN:    state_next = ST_RSCAN;
                        default:               state_next = ST_STAT;
                    endcase
                end
            end
            ST_ASG: begin
                if (stat.emit_ok) begin
                    cmd.dispatch = 1'b1;
                    cmd.last     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_CST: begin
                if (stat.emit_ok) begin
                    if (stat.reject) begin
                        cmd.reject = 1'b1;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        cmd.crash_stat = 1'b1;
                        cmd.last       = stat.idx_fill_zero;
                        state_next     = stat.idx_fill_zero ? ST_IDLE : ST_CRD;
                    end
                end
            end
            ST_CRD: begin
                cmd.pop       = 1'b1;
                cmd.pop_crash = 1'b1;
                state_next    = ST_CDSP;
            end
            ST_CDSP: begin
                if (stat.emit_ok) begin
                    cmd.dispatch = 1'b1;
                    cmd.src_pop  = 1'b1;
                    cmd.last     = stat.idx_fill_zero;
                    state_next   = stat.idx_fill_zero ? ST_IDLE : ST_CRD;
                end
            end
            ST_RSCAN: begin
                if (!stat.more_work) begin
                    if (stat.emit_ok) begin
                        cmd.idle   = 1'b1;
                        cmd.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                end else if (stat.cur_work) begin
                    cmd.pop    = 1'b1;
                    state_next = ST_REMIT;
                end else begin
                    cur_next = cur_reg + lldf_pkg::NODE_BITS'(1);
                end
            end
            ST_REMIT: begin
                if (stat.emit_ok) begin
                    cmd.exec   = 1'b1;
                    cmd.last   = !stat.more_work;
                    state_next = stat.more_work ? ST_RSCAN : ST_IDLE;
                end
            end
            ST_STAT: begin
                if (stat.emit_ok) begin
                    cmd.stat   = 1'b1;
                    cmd.last   = stat.last_node;
                    cur_next   = cur_reg + lldf_pkg::NODE_BITS'(1);
                    state_next = stat.last_node ? ST_IDLE : ST_STAT;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cur_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("transaction accepted without starting work");

    a_final_goes_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.last && (state_reg != ST_IDLE)) |=> (state_reg == ST_IDLE))
        else $error("final result issued while work remains");

    a_scan_has_work: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_REMIT) && ($past(state_reg) != ST_REMIT)) |-> $past(cmd.pop))
        else $error("execute step without a queue read");

endmodule

### sv/least_loaded_dispatcher_failover.sv
// ---------------------------------------------------------------------------
// least_loaded_dispatcher_failover: join-shortest-queue task dispatcher
// Per-node task queues with least-loaded placement, crash failover,
// queue drain and status report.
//
//   Channel  Ports                      Direction  Content
//   input    s_valid/s_ready/s_data     in         func, task, node to crash
//   result   m_valid/m_ready/m_data     out        one or more per transaction
//   config   cfg_wr_en/cfg_wr_data      in         active_nodes register
//
// Assign: accept, then select and write. Crash: accept, status, then a read
// and a dispatch per moved task. Run: accept, a scan step per node without work
// passed before the last busy one, a read then a result per executed task; an
// idle run gives one idle result. Status: one result per node in use. Results
// wait in one register; a stalled one holds up the next. s_ready is high in idle.
// Reset (aresetn low, synchronous) empties all queues and revives all nodes.
// ---------------------------------------------------------------------------
module least_loaded_dispatcher_failover (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  lldf_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lldf_pkg::out_item_t           m_data,
    input  logic                          cfg_wr_en,
    input  logic [lldf_pkg::CFG_BITS-1:0] cfg_wr_data
);

    lldf_pkg::dp_cmd_t  cmd;
    lldf_pkg::dp_stat_t stat;

    lldf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_data.func),
        .cmd     (cmd),
        .stat    (stat)
    );

    lldf_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .m_data      (m_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

### sim/least_loaded_dispatcher_failover_test.sv
// ---------------------------------------------------------------------------
// least_loaded_dispatcher_failover_test: self-checking bench for the dispatcher
// Directed cases first: extreme task fields, status and run, rejected crash,
// queue-full drop, failover to the remaining node and a dead cluster. Then
// random command mixes over several active_nodes settings, with random idling
// on both channels, a long output hold-off and a stretch with no idling.
// Expected results come from a cycle-free model of the node queues.
// ---------------------------------------------------------------------------
module least_loaded_dispatcher_failover_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 10;
    localparam int END_CYCLES     = 50;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    lldf_pkg::in_item_t            s_data      = '0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    lldf_pkg::out_item_t           m_data;
    logic                          cfg_wr_en   = 1'b0;
    logic [lldf_pkg::CFG_BITS-1:0] cfg_wr_data = '0;

    least_loaded_dispatcher_failover dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Dispatcher model state
    logic [lldf_pkg::ENTRY_BITS-1:0] task_slots [lldf_pkg::MEM_DEPTH];
    int unsigned                     queue_start [lldf_pkg::NODE_COUNT];
    int unsigned                     queue_len [lldf_pkg::NODE_COUNT];
    bit                              node_up [lldf_pkg::NODE_COUNT];
    logic [lldf_pkg::DONE_BITS-1:0]  node_done_cnt [lldf_pkg::NODE_COUNT];
    logic [lldf_pkg::CFG_BITS-1:0]   active_cfg;
    lldf_pkg::out_item_t             pending_reports [$];

    int  fail_count      = 0;
    int  commands_sent   = 0;
    int  reports_checked = 0;
    bit  steady          = 1'b0;
    int  holds_requested = 0;
    int  holds_served    = 0;
    int  stall_cycles    = 0;

    function automatic void reset_model();
        for (int i = 0; i < lldf_pkg::NODE_COUNT; i++) begin
            queue_start[i]   = 0;
            queue_len[i]     = 0;
            node_up[i]       = 1'b1;
            node_done_cnt[i] = '0;
        end
        active_cfg = lldf_pkg::CFG_RESET;
    endfunction

    function automatic int unsigned nodes_in_use();
        int unsigned n;
        n = 32'(active_cfg);
        if (n < 1) n = 1;
        if (n > lldf_pkg::NODE_COUNT) n = lldf_pkg::NODE_COUNT;
        return n;
    endfunction

    function automatic void post_report(logic [lldf_pkg::KIND_BITS-1:0] kind,
                                        int unsigned node,
                                        logic [lldf_pkg::ID_BITS-1:0] id,
                                        logic [lldf_pkg::TYPE_BITS-1:0] ttype,
                                        bit alive, logic [lldf_pkg::DONE_BITS-1:0] done);
        lldf_pkg::out_item_t r;
        r.kind          = kind;
        r.node          = lldf_pkg::NODE_BITS'(node);
        r.task_id_res   = id;
        r.task_type_res = ttype;
        r.alive         = alive;
        r.done_count    = done;
        r.last          = 1'b0;
        pending_reports = {pending_reports, r};
    endfunction

    // Least-loaded placement, lowest index on a tie
    function automatic void place_task(logic [lldf_pkg::ID_BITS-1:0] id,
                                       logic [lldf_pkg::TYPE_BITS-1:0] ttype);
        int          sel;
        int unsigned slot;
        sel = -1;
        for (int i = 0; i < nodes_in_use(); i++) begin
            if (node_up[i] && queue_len[i] < lldf_pkg::QUEUE_DEPTH &&
                (sel < 0 || queue_len[i] < queue_len[sel])) sel = i;
        end
        if (sel < 0) begin
            post_report(lldf_pkg::KIND_DROPPED, 0, id, ttype, 1'b0, '0);
        end else begin
            slot = (queue_start[sel] + queue_len[sel]) % lldf_pkg::QUEUE_DEPTH;
            task_slots[sel * lldf_pkg::QUEUE_DEPTH + slot] = {id, ttype};
            queue_len[sel]++;
            post_report(lldf_pkg::KIND_ASSIGNED, sel, id, ttype, 1'b0, '0);
        end
    endfunction

    function automatic logic [lldf_pkg::ENTRY_BITS-1:0] take_task(int unsigned nd);
        logic [lldf_pkg::ENTRY_BITS-1:0] e;
        e = task_slots[nd * lldf_pkg::QUEUE_DEPTH + queue_start[nd]];
        queue_start[nd] = (queue_start[nd] + 1) % lldf_pkg::QUEUE_DEPTH;
        queue_len[nd]--;
        return e;
    endfunction

    function automatic void apply_command(lldf_pkg::in_item_t c);
        int unsigned                     n;
        int                              executed;
        logic [lldf_pkg::ENTRY_BITS-1:0] e;
        n        = nodes_in_use();
        executed = 0;
        case (c.func)
            lldf_pkg::FUNC_ASSIGN: begin
                place_task(c.task_id, c.task_type);
            end
            lldf_pkg::FUNC_CRASH: begin
                if (c.node_index >= n) begin
                    post_report(lldf_pkg::KIND_REJECTED, c.node_index, '0, '0, 1'b0, '0);
                end else begin
                    node_up[c.node_index] = 1'b0;
                    post_report(lldf_pkg::KIND_STATUS, c.node_index, '0, '0, 1'b0,
                                node_done_cnt[c.node_index]);
                    while (queue_len[c.node_index] > 0) begin
                        e = take_task(c.node_index);
                        place_task(e[lldf_pkg::ENTRY_BITS-1:lldf_pkg::TYPE_BITS],
                                   e[lldf_pkg::TYPE_BITS-1:0]);
                    end
                    queue_start[c.node_index] = 0;
                end
            end
            lldf_pkg::FUNC_RUN: begin
                for (int i = 0; i < n; i++) begin
                    if (node_up[i]) begin
                        while (queue_len[i] > 0) begin
                            e = take_task(i);
                            if (node_done_cnt[i] != '1) node_done_cnt[i]++;
                            post_report(lldf_pkg::KIND_EXECUTED, i,
                                        e[lldf_pkg::ENTRY_BITS-1:lldf_pkg::TYPE_BITS],
                                        e[lldf_pkg::TYPE_BITS-1:0], 1'b0, '0);
                            executed++;
                        end
                    end
                end
                if (executed == 0) begin
                    post_report(lldf_pkg::KIND_RUN_IDLE, 0, '0, '0, 1'b0, '0);
                end
            end
            default: begin
                for (int i = 0; i < n; i++)
                    post_report(lldf_pkg::KIND_STATUS, i, '0, '0, node_up[i],
                                node_done_cnt[i]);
            end
        endcase
        pending_reports[pending_reports.size() - 1].last = 1'b1;
    endfunction

    function automatic lldf_pkg::in_item_t make_cmd(logic [lldf_pkg::FUNC_BITS-1:0] func,
                                                    logic [lldf_pkg::ID_BITS-1:0] id,
                                                    logic [lldf_pkg::TYPE_BITS-1:0] ttype,
                                                    logic [lldf_pkg::NODE_BITS-1:0] idx);
        lldf_pkg::in_item_t c;
        c.func       = func;
        c.task_id    = id;
        c.task_type  = ttype;
        c.node_index = idx;
        return c;
    endfunction

    // Crashes of live in-use nodes only when allow_kill is set
    function automatic lldf_pkg::in_item_t random_cmd(int unsigned assign_pct, bit allow_kill);
        lldf_pkg::in_item_t c;
        int unsigned        roll;
        int unsigned        rest;
        roll = $urandom_range(0, 99);
        rest = $urandom_range(0, 9);
        c = make_cmd(lldf_pkg::FUNC_ASSIGN,
                     lldf_pkg::ID_BITS'($urandom_range(0, 16'hFFFF)),
                     lldf_pkg::TYPE_BITS'($urandom_range(0, 3)),
                     lldf_pkg::NODE_BITS'($urandom_range(0, 3)));
        if (roll >= assign_pct) begin
            if (rest < 5) c.func = lldf_pkg::FUNC_RUN;
            else if (rest < 7) c.func = lldf_pkg::FUNC_STATUS;
            else c.func = lldf_pkg::FUNC_CRASH;
        end
        if (c.func == lldf_pkg::FUNC_CRASH && !allow_kill && c.node_index < nodes_in_use() &&
            node_up[c.node_index]) c.func = lldf_pkg::FUNC_STATUS;
        return c;
    endfunction

    task automatic send_cmd(input lldf_pkg::in_item_t c);
        if (!steady && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(0, 99) < 20) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        do @(posedge aclk); while (!s_ready);
        apply_command(c);
        commands_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic set_active_nodes(input logic [lldf_pkg::CFG_BITS-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        active_cfg = value;
    endtask

    task automatic run_random(input int count, input int unsigned assign_pct,
                              input bit allow_kill);
        repeat (count) send_cmd(random_cmd(assign_pct, allow_kill));
    endtask

    task automatic test_assign_and_report();
        send_cmd(make_cmd(lldf_pkg::FUNC_ASSIGN, 16'h0000, 2'd0, 2'd3));
        send_cmd(make_cmd(lldf_pkg::FUNC_ASSIGN, 16'hFFFF, 2'd1, 2'd0));
        send_cmd(make_cmd(lldf_pkg::FUNC_ASSIGN, 16'h5555, 2'd2, 2'd1));
        send_cmd(make_cmd(lldf_pkg::FUNC_ASSIGN, 16'hAAAA, 2'd3, 2'd2));
        send_cmd(make_cmd(lldf_pkg::FUNC_STATUS, 16'h0000, 2'd0, 2'd0));
        send_cmd(make_cmd(lldf_pkg::FUNC_RUN, 16'h0000, 2'd0, 2'd0));
        send_cmd(make_cmd(lldf_pkg::FUNC_RUN, 16'hFFFF, 2'd3, 2'd3));
    endtask

    task automatic test_rejected_crash();
        set_active_nodes(3'd0);
        send_cmd(make_cmd(lldf_pkg::FUNC_CRASH, 16'h1234, 2'd1, 2'd3));
        send_cmd(make_cmd(lldf_pkg::FUNC_CRASH, 16'h0000, 2'd0, 2'd1));
    endtask

    task automatic test_queue_full();
        repeat (lldf_pkg::QUEUE_DEPTH + 1)
            send_cmd(make_cmd(lldf_pkg::FUNC_ASSIGN,
                              lldf_pkg::ID_BITS'($urandom_range(0, 16'hFFFF)),
                              lldf_pkg::TYPE_BITS'($urandom_range(0, 3)),
                              lldf_pkg::NODE_BITS'($urandom_range(0, 3))));
    endtask

    task automatic test_failover();
        set_active_nodes(3'd2);
        send_cmd(make_cmd(lldf_pkg::FUNC_CRASH, 16'h0000, 2'd0, 2'd0));
    endtask

    task automatic test_no_live_node();
        set_active_nodes(3'd1);
        send_cmd(make_cmd(lldf_pkg::FUNC_ASSIGN, 16'hBEEF, 2'd2, 2'd1));
        send_cmd(make_cmd(lldf_pkg::FUNC_CRASH, 16'h0000, 2'd0, 2'd0));
        send_cmd(make_cmd(lldf_pkg::FUNC_STATUS, 16'h0000, 2'd0, 2'd0));
    endtask

    task automatic test_steady_traffic();
        set_active_nodes(3'd3);
        steady = 1'b1;
        run_random(25, 60, 1'b0);
        steady = 1'b0;
    endtask

    task automatic test_output_backpressure();
        set_active_nodes(3'd4);
        holds_requested++;
        run_random(25, 60, 1'b0);
    endtask

    task automatic test_overload();
        set_active_nodes(3'd7);
        run_random(25, 90, 1'b0);
    endtask

    task automatic test_partial_use();
        set_active_nodes(3'd2);
        run_random(20, 60, 1'b0);
    endtask

    task automatic test_crash_storm();
        set_active_nodes(3'd5);
        run_random(25, 55, 1'b1);
    endtask

    task automatic test_dead_cluster();
        set_active_nodes(3'd1);
        run_random(10, 50, 1'b1);
    endtask

    function automatic bit field_ok(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        lldf_pkg::out_item_t want;
        bit                  ok;
        if (aresetn && m_valid && m_ready) begin
            reports_checked++;
            if (pending_reports.size() == 0) begin
                $error("unexpected result transaction: kind %0d node %0d",
                       m_data.kind, m_data.node);
                fail_count++;
            end else begin
                want = pending_reports.pop_front();
                ok = field_ok("kind", 32'(want.kind), 32'(m_data.kind));
                ok &= field_ok("node", 32'(want.node), 32'(m_data.node));
                ok &= field_ok("task_id_res", 32'(want.task_id_res),
                               32'(m_data.task_id_res));
                ok &= field_ok("task_type_res", 32'(want.task_type_res),
                               32'(m_data.task_type_res));
                ok &= field_ok("alive", 32'(want.alive), 32'(m_data.alive));
                ok &= field_ok("done_count", 32'(want.done_count), 32'(m_data.done_count));
                ok &= field_ok("last", 32'(want.last), 32'(m_data.last));
                if (!ok) fail_count++;
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (holds_served != holds_requested) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= steady || ($urandom_range(0, 99) >= 20);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_assign_and_report();
        test_rejected_crash();
        test_queue_full();
        test_failover();
        test_no_live_node();
        test_steady_traffic();
        test_output_backpressure();
        test_overload();
        test_partial_use();
        test_crash_storm();
        test_dead_cluster();
        wait_drained();
        repeat (END_CYCLES) @(posedge aclk);
        $display("Sent %0d commands, checked %0d results; active_nodes 0 to 7,", commands_sent,
                 reports_checked);
        $display("full-queue drops, crash failover, dead cluster and output hold-off covered.");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

### sim.f
sv/lldf_pkg.sv
sv/lldf_dp.sv
sv/lldf_ctrl.sv
sv/least_loaded_dispatcher_failover.sv
sim/least_loaded_dispatcher_failover_test.sv
